// ----- rtl/slru_pkg.sv -----
`default_nettype none

package slru_pkg;

    // Result codes
    typedef enum logic [1:0] {
        OUT_APPEND  = 2'd0,
        OUT_REPLACE = 2'd1,
        OUT_REJECT  = 2'd2
    } t_outcome;

    localparam int START_W = 8;
    localparam int CAP_W = 9;
    localparam int ID_W = 32;
    localparam int TIME_W = 32;
    localparam int SLOT_W = 8;
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

endpackage

`default_nettype wire

// ----- rtl/sampled_lru_insert_top.sv -----
`default_nettype none

// Sampled LRU insert: offers one entry (id, access time) per request to a slot
// store of DEPTH entries held in two RAMs, each with one read and one write
// port. While the fill count is below min(capacity, DEPTH) the entry is
// appended, and the result shows in the cycle after the request is taken.
// If the store is empty and the limit is zero, the entry is rejected at once.
// Otherwise the sample start is reduced modulo the fill count by a shared
// compare-and-subtract stage, one bit of the start per cycle, then
// NUM_SAMPLES timestamps are read one per cycle through the timestamp RAM
// port and folded into a running minimum. If that minimum is later than the
// new access time the entry is rejected; else a replacement reads the victim
// id in the pick state and writes the new entry in the swap state before the
// result shows. Only one request is in work at a time: o_ready is low from
// acceptance until the result is taken. The capacity register may be written
// at any time the block is idle; it resets to 256.
// Stored entries are undefined until written; only filled slots are read.
module sampled_lru_insert_top #(
    parameter int DEPTH       = 256,
    parameter int NUM_SAMPLES = 8
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_ready,
    input  wire  [slru_pkg::ID_W-1:0]           i_entry_id,
    input  wire  [slru_pkg::TIME_W-1:0]         i_access_time,
    input  wire  [slru_pkg::START_W-1:0]        i_sample_start,
    output logic                                o_valid,
    input  wire                                 i_ready,
    output slru_pkg::t_outcome                  o_outcome,
    output logic [slru_pkg::SLOT_W-1:0]         o_slot,
    output logic [slru_pkg::ID_W-1:0]           o_out_id,
    output logic [slru_pkg::TIME_W-1:0]         o_out_time,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [slru_pkg::CAP_W-1:0]          i_cfg_data
);
    import slru_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam int LW = (FW > CAP_W) ? FW : CAP_W;
    localparam int CW = $clog2(NUM_SAMPLES + 1);
    localparam int STW = $clog2(START_W);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MOD  = 6'b000010,
        S_SCAN = 6'b000100,
        S_PICK = 6'b001000,
        S_SWAP = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [CAP_W-1:0]    r_cap, n_cap;
    logic [FW-1:0]       r_fill, n_fill;
    logic                r_cmp_vld, n_cmp_vld;

    logic [ID_W-1:0]     r_id, n_id;
    logic [TIME_W-1:0]   r_time, n_time;
    logic [START_W-1:0]  r_sbits, n_sbits;
    logic [FW-1:0]       r_rem, n_rem;
    logic [STW-1:0]      r_step, n_step;
    logic [AW-1:0]       r_pos, n_pos;
    logic [CW-1:0]       r_issue, n_issue;
    logic [AW-1:0]       r_cmp_pos, n_cmp_pos;
    logic                r_first, n_first;
    logic [TIME_W-1:0]   r_oldest, n_oldest;
    logic [AW-1:0]       r_victim, n_victim;
    t_outcome            r_outcome, n_outcome;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [ID_W-1:0]     r_oid, n_oid;
    logic [TIME_W-1:0]   r_otime, n_otime;

    logic [ID_W-1:0]     r_ids [DEPTH];
    logic [TIME_W-1:0]   r_times [DEPTH];
    logic [ID_W-1:0]     r_rd_id;
    logic [TIME_W-1:0]   r_rd_time;

    logic                mem_we;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;
    logic [ID_W-1:0]     wr_id;
    logic [TIME_W-1:0]   wr_time;

    logic [LW-1:0]       limit;
    logic                do_append;
    logic                accept;
    logic [FW:0]         rem_sh;
    logic                rem_ge;
    logic [FW-1:0]       rem_next;
    logic [FW-1:0]       pos_inc;
    logic                issuing;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = (r_state == S_OUT);
    assign o_outcome   = r_outcome;
    assign o_slot      = r_slot;
    assign o_out_id    = r_oid;
    assign o_out_time  = r_otime;

    assign accept    = i_valid && o_ready;
    assign limit     = (LW'(r_cap) < LW'(DEPTH)) ? LW'(r_cap) : LW'(DEPTH);
    assign do_append = LW'(r_fill) < limit;

    // One step of restoring remainder: shift in the next start bit.
    assign rem_sh   = {r_rem, r_sbits[START_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, r_fill};
    assign rem_next = rem_ge ? FW'(rem_sh - {1'b0, r_fill}) : FW'(rem_sh);

    assign pos_inc = FW'(r_pos) + FW'(1);
    assign issuing = (r_state == S_SCAN) && (r_issue < CW'(NUM_SAMPLES));

    assign rd_addr = (r_state == S_SCAN) ? r_pos : r_victim;
    assign mem_we  = (accept && do_append) || (r_state == S_SWAP);
    assign wr_addr = (r_state == S_SWAP) ? r_victim : r_fill[AW-1:0];
    assign wr_id   = (r_state == S_SWAP) ? r_id : i_entry_id;
    assign wr_time = (r_state == S_SWAP) ? r_time : i_access_time;

    always_comb begin
        n_state   = r_state;
        n_cap     = r_cap;
        n_fill    = r_fill;
        n_cmp_vld = 1'b0;
        n_id      = r_id;
        n_time    = r_time;
        n_sbits   = r_sbits;
        n_rem     = r_rem;
        n_step    = r_step;
        n_pos     = r_pos;
        n_issue   = r_issue;
        n_cmp_pos = r_cmp_pos;
        n_first   = r_first;
        n_oldest  = r_oldest;
        n_victim  = r_victim;
        n_outcome = r_outcome;
        n_slot    = r_slot;
        n_oid     = r_oid;
        n_otime   = r_otime;

        if (i_cfg_valid) begin
            n_cap = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_id    = i_entry_id;
                    n_time  = i_access_time;
                    n_sbits = i_sample_start;
                    priority if (do_append) begin
                        n_fill    = r_fill + FW'(1);
                        n_outcome = OUT_APPEND;
                        n_slot    = SLOT_W'(r_fill);
                        n_oid     = '0;
                        n_otime   = '0;
                        n_state   = S_OUT;
                    end else if (r_fill == '0) begin
                        n_outcome = OUT_REJECT;
                        n_slot    = '0;
                        n_oid     = i_entry_id;
                        n_otime   = i_access_time;
                        n_state   = S_OUT;
                    end else begin
                        n_rem   = '0;
                        n_step  = STW'(START_W - 1);
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                n_rem   = rem_next;
                n_sbits = {r_sbits[START_W-2:0], 1'b0};
                n_step  = r_step - STW'(1);
                if (r_step == '0) begin
                    n_pos   = AW'(rem_next);
                    n_issue = '0;
                    n_first = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (issuing) begin
                    n_cmp_vld = 1'b1;
                    n_cmp_pos = r_pos;
                    n_issue   = r_issue + CW'(1);
                    n_pos     = (pos_inc >= r_fill) ? '0 : AW'(pos_inc);
                end
                // Fold in the sample read last cycle; first minimum wins.
                if (r_cmp_vld) begin
                    if (r_first || (r_rd_time < r_oldest)) begin
                        n_oldest = r_rd_time;
                        n_victim = r_cmp_pos;
                    end
                    n_first = 1'b0;
                    if (r_issue == CW'(NUM_SAMPLES)) begin
                        n_state = S_PICK;
                    end
                end
            end
            S_PICK: begin
                if (r_oldest > r_time) begin
                    n_outcome = OUT_REJECT;
                    n_slot    = '0;
                    n_oid     = r_id;
                    n_otime   = r_time;
                    n_state   = S_OUT;
                end else begin
                    n_state = S_SWAP;
                end
            end
            S_SWAP: begin
                n_outcome = OUT_REPLACE;
                n_slot    = SLOT_W'(r_victim);
                n_oid     = r_rd_id;
                n_otime   = r_oldest;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cap     <= CAP_RESET;
            r_fill    <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cap     <= n_cap;
            r_fill    <= n_fill;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id      <= n_id;
        r_time    <= n_time;
        r_sbits   <= n_sbits;
        r_rem     <= n_rem;
        r_step    <= n_step;
        r_pos     <= n_pos;
        r_issue   <= n_issue;
        r_cmp_pos <= n_cmp_pos;
        r_first   <= n_first;
        r_oldest  <= n_oldest;
        r_victim  <= n_victim;
        r_outcome <= n_outcome;
        r_slot    <= n_slot;
        r_oid     <= n_oid;
        r_otime   <= n_otime;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ids[wr_addr]   <= wr_id;
            r_times[wr_addr] <= wr_time;
        end
        r_rd_id   <= r_ids[rd_addr];
        r_rd_time <= r_times[rd_addr];
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("fill count exceeds store depth");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("new request taken while a result is pending");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (FW'(r_pos) < r_fill))
        else $error("sample address outside filled slots");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && do_append) |=> (r_fill == $past(r_fill) + FW'(1)))
        else $error("append did not advance fill count");
`endif

endmodule

`default_nettype wire

// ----- sim/sampled_lru_insert_top_test.sv -----
module sampled_lru_insert_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import slru_pkg::*;

    localparam int DEPTH       = 256;
    localparam int NUM_SAMPLES = 8;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        t_outcome            outcome;
        logic [SLOT_W-1:0]   slot;
        logic [ID_W-1:0]     id;
        logic [TIME_W-1:0]   stamp;
    } t_insert_verdict;

    class t_slot_store #(int SLOTS = 256, int SAMPLES = 8);
        logic [ID_W-1:0]   ids    [SLOTS];
        logic [TIME_W-1:0] stamps [SLOTS];
        int unsigned       fill = 0;
        int unsigned       capacity = CAP_RESET;
        int unsigned       mismatches = 0;
        t_insert_verdict   pending_verdicts [$];

        function int outstanding();
            return pending_verdicts.size();
        endfunction

        // Predict the verdict for an accepted insert and update the store.
        function void offer_entry(logic [ID_W-1:0] id, logic [TIME_W-1:0] stamp,
                                  logic [START_W-1:0] start);
            t_insert_verdict v;
            int unsigned usable, pos, victim, k;
            logic [TIME_W-1:0] oldest;
            usable = (capacity < SLOTS) ? capacity : SLOTS;
            if (fill < usable) begin
                ids[fill]    = id;
                stamps[fill] = stamp;
                v = '{OUT_APPEND, SLOT_W'(fill), '0, '0};
                fill++;
            end else if (fill == 0) begin
                v = '{OUT_REJECT, '0, id, stamp};
            end else begin
                pos    = start % fill;
                victim = pos;
                oldest = stamps[pos];
                for (k = 0; k < SAMPLES; k++) begin
                    // strict compare: first minimum in window order wins
                    if (stamps[pos] < oldest) begin
                        oldest = stamps[pos];
                        victim = pos;
                    end
                    pos++;
                    if (pos >= fill) pos = 0;
                end
                if (oldest > stamp) begin
                    v = '{OUT_REJECT, '0, id, stamp};
                end else begin
                    v = '{OUT_REPLACE, SLOT_W'(victim), ids[victim], stamps[victim]};
                    ids[victim]    = id;
                    stamps[victim] = stamp;
                end
            end
            pending_verdicts.push_back(v);
        endfunction

        function void check_verdict(t_outcome outcome, logic [SLOT_W-1:0] slot,
                                    logic [ID_W-1:0] id, logic [TIME_W-1:0] stamp);
            t_insert_verdict want;
            if (pending_verdicts.size() == 0) begin
                $error("unexpected result: outcome %0d slot %0d id %h stamp %h",
                       outcome, slot, id, stamp);
                mismatches++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (outcome !== want.outcome) begin
                $error("outcome mismatch: expected %0d, actual %0d", want.outcome, outcome);
                mismatches++;
            end
            if (slot !== want.slot) begin
                $error("slot mismatch: expected %0d, actual %0d", want.slot, slot);
                mismatches++;
            end
            if (id !== want.id) begin
                $error("out_id mismatch: expected %h, actual %h", want.id, id);
                mismatches++;
            end
            if (stamp !== want.stamp) begin
                $error("out_time mismatch: expected %h, actual %h", want.stamp, stamp);
                mismatches++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [ID_W-1:0]    i_entry_id;
    logic [TIME_W-1:0]  i_access_time;
    logic [START_W-1:0] i_sample_start;
    logic               o_valid;
    logic               i_ready;
    t_outcome           o_outcome;
    logic [SLOT_W-1:0]  o_slot;
    logic [ID_W-1:0]    o_out_id;
    logic [TIME_W-1:0]  o_out_time;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CAP_W-1:0]   i_cfg_data;

    t_slot_store #(DEPTH, NUM_SAMPLES) model = new;
    logic [TIME_W-1:0] now_stamp = 32'd1000;
    int unsigned       cycles = 0;

    sampled_lru_insert_top #(
        .DEPTH       (DEPTH),
        .NUM_SAMPLES (NUM_SAMPLES)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_entry_id     (i_entry_id),
        .i_access_time  (i_access_time),
        .i_sample_start (i_sample_start),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_outcome      (o_outcome),
        .o_slot         (o_slot),
        .o_out_id       (o_out_id),
        .o_out_time     (o_out_time),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            model.check_verdict(o_outcome, o_slot, o_out_id, o_out_time);
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int stall_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int sender_gap(bit steady);
        if (steady || $urandom_range(0, 1) == 0) return 0;
        return stall_cycles();
    endfunction

    // Mostly advancing access times, plus stale, random, tied and extreme ones.
    function automatic logic [TIME_W-1:0] next_stamp();
        int roll;
        roll = $urandom_range(0, 99);
        now_stamp = now_stamp + $urandom_range(0, 3000);
        if (roll < 60) return now_stamp;
        if (roll < 75) return now_stamp - $urandom_range(0, 20000);
        if (roll < 85) return $urandom;
        if (roll < 93) return $urandom_range(0, 7);
        return ($urandom_range(0, 1) == 0) ? '0 : '1;
    endfunction

    initial begin : sink_pacing
        i_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(200, 400)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
            i_ready <= 1'b0;
            repeat (stall_cycles()) @(posedge i_clk);
        end
    end

    task automatic offer(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] stamp,
                         input logic [START_W-1:0] start, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_entry_id     <= id;
        i_access_time  <= stamp;
        i_sample_start <= start;
        do @(posedge i_clk); while (!o_ready);
        model.offer_entry(id, stamp, start);
    endtask

    // Hold off new requests until every pending result is back.
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (model.outstanding() != 0);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        model.capacity = cap;
    endtask

    task automatic run_phase(input logic [CAP_W-1:0] cap, input int count);
        bit steady;
        steady = ($urandom_range(0, 3) == 0);
        write_capacity(cap);
        for (int n = 0; n < count; n++) begin
            if (n == count / 2 || $urandom_range(0, 199) == 0) drain();
            offer($urandom, next_stamp(), START_W'($urandom_range(0, 255)),
                  sender_gap(steady));
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_entry_id     <= '0;
        i_access_time  <= '0;
        i_sample_start <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_data     <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero limit on an empty store: nothing to sample, reject.
        write_capacity(9'd0);
        offer('0, '0, 8'd0, sender_gap(0));
        offer('1, '1, 8'd255, sender_gap(0));

        // Single slot: the window wraps onto the same entry every sample.
        write_capacity(9'd1);
        offer(32'd1, 32'd100, 8'd0, sender_gap(0));
        offer(32'd2, 32'd100, 8'd255, sender_gap(0));
        offer(32'd3, 32'd99, 8'd7, sender_gap(0));
        offer(32'd4, '1, 8'd1, sender_gap(0));

        // Duplicate oldest times: the first one in window order is evicted.
        write_capacity(9'd5);
        offer(32'd5, 32'd50, 8'd0, sender_gap(0));
        offer(32'd6, 32'd20, 8'd0, sender_gap(0));
        offer(32'd7, 32'd20, 8'd0, sender_gap(0));
        offer(32'd8, 32'd70, 8'd0, sender_gap(0));
        offer(32'd9, 32'd20, 8'd3, sender_gap(0));
        offer(32'd10, 32'd19, 8'd0, sender_gap(0));
        offer(32'd11, 32'd0, 8'd200, sender_gap(0));
        offer(32'd12, 32'd1000, 8'd254, sender_gap(0));

        // Limit beyond the store size clamps to DEPTH.
        write_capacity(9'd511);
        offer(32'hAAAA_AAAA, 32'h5555_5555, 8'hAA, sender_gap(0));
        offer(32'h5555_5555, 32'hAAAA_AAAA, 8'h55, sender_gap(0));
        offer(32'hFFFF_0000, 32'h0000_FFFF, 8'h0F, sender_gap(0));

        // Limit below the fill count: sample among all stored entries.
        write_capacity(9'd2);
        offer(32'd13, '1, 8'd9, sender_gap(0));
        offer(32'd14, '0, 8'd128, sender_gap(0));

        run_phase(9'd12, 170);
        run_phase(9'd6, 170);
        run_phase(9'd40, 170);
        run_phase(9'd30, 170);
        run_phase(9'd160, 170);
        run_phase(9'd511, 170);
        run_phase(9'd200, 170);
        run_phase(9'd256, 170);
        run_phase(9'd3, 170);
        run_phase(9'd1, 160);
        run_phase(9'd256, 170);

        drain();
        repeat (40) @(posedge i_clk);
        if (model.outstanding() != 0) begin
            $error("%0d expected results never arrived", model.outstanding());
        end
        if (model.mismatches == 0 && model.outstanding() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/slru_pkg.sv
rtl/sampled_lru_insert_top.sv
sim/sampled_lru_insert_top_test.sv
